>>> hw/rtl/dxt1_pkg.sv
`timescale 1ns / 1ps

package dxt1_pkg;

	// block geometry
	localparam int unsigned RowsPerBlock = 4;
	localparam int unsigned PixPerRow    = 4;
	localparam int unsigned PixW         = 32;
	localparam int unsigned IdxW         = 2;
	localparam int unsigned RowIdxW      = PixPerRow * IdxW;
	localparam int unsigned RowNumW      = $clog2(RowsPerBlock);
	localparam logic [RowNumW-1:0] LastRow = RowNumW'(RowsPerBlock - 1);

	// palette queue between front and back
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

	// channel constants
	localparam logic [7:0] AlphaOpaque = 8'hff;
	localparam logic [7:0] AlphaClear  = 8'h00;

	// x / 3 as (x * 683) >> 11, exact for x below 2048
	localparam logic [9:0] Recip3      = 10'd683;
	localparam int unsigned Recip3Shift = 11;

	typedef logic [PixW-1:0] pixel_t;

	// one decoded block waiting for the back end
	typedef struct packed {
		pixel_t [IdxW**2-1:0]                palette;
		logic   [RowsPerBlock-1:0][RowIdxW-1:0] idx_rows;
	} dxt1_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} dxt1_qstat_t;

	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'(Recip3);
		return p[Recip3Shift +: 8];
	endfunction

	// (2*a + b) / 3
	function automatic logic [7:0] blend_21(input logic [7:0] a, input logic [7:0] b);
		return div3({1'b0, a, 1'b0} + {2'b00, b});
	endfunction

	// (a + b) / 2
	function automatic logic [7:0] blend_11(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

endpackage

>>> hw/rtl/dxt1_if.sv
`timescale 1ns / 1ps

// compressed block channel
interface dxt1_blk_if;
	logic        valid;
	logic        ready;
	logic [15:0] endpoint_first;
	logic [15:0] endpoint_second;
	logic [31:0] index_bits;

	modport source (output valid, output endpoint_first, output endpoint_second,
		output index_bits, input ready);
	modport sink (input valid, input endpoint_first, input endpoint_second,
		input index_bits, output ready);
endinterface

// decoded pixel row channel
interface dxt1_row_if;
	logic        valid;
	logic        ready;
	logic [1:0]  row_number;
	logic [31:0] pixel_zero;
	logic [31:0] pixel_one;
	logic [31:0] pixel_two;
	logic [31:0] pixel_three;
	logic        last_row;

	modport source (output valid, output row_number, output pixel_zero, output pixel_one,
		output pixel_two, output pixel_three, output last_row, input ready);
	modport sink (input valid, input row_number, input pixel_zero, input pixel_one,
		input pixel_two, input pixel_three, input last_row, output ready);
endinterface

>>> hw/rtl/dxt1_front.sv
`timescale 1ns / 1ps

module dxt1_front
	import dxt1_pkg::*;
(
	dxt1_blk_if.sink    blk,
	input  dxt1_qstat_t qstat,
	output logic        push,
	output dxt1_entry_t push_entry
);

	logic [7:0] r0, g0, b0, r1, g1, b1;
	logic       four_color;

	// take a request whenever the queue has room
	assign blk.ready = !qstat.full;
	assign push      = blk.valid && !qstat.full;

	// expand endpoints by shifting, low bits zero
	assign r0 = {blk.endpoint_first[15:11], 3'b000};
	assign g0 = {blk.endpoint_first[10:5], 2'b00};
	assign b0 = {blk.endpoint_first[4:0], 3'b000};
	assign r1 = {blk.endpoint_second[15:11], 3'b000};
	assign g1 = {blk.endpoint_second[10:5], 2'b00};
	assign b1 = {blk.endpoint_second[4:0], 3'b000};

	// strict compare picks four-color mode
	assign four_color = blk.endpoint_first > blk.endpoint_second;

	// build palette
	always_comb begin
		push_entry.palette[0] = {r0, g0, b0, AlphaOpaque};
		push_entry.palette[1] = {r1, g1, b1, AlphaOpaque};
		if (four_color) begin
			push_entry.palette[2] = {blend_21(r0, r1), blend_21(g0, g1), blend_21(b0, b1),
				AlphaOpaque};
			push_entry.palette[3] = {blend_21(r1, r0), blend_21(g1, g0), blend_21(b1, b0),
				AlphaOpaque};
		end else begin
			push_entry.palette[2] = {blend_11(r0, r1), blend_11(g0, g1), blend_11(b0, b1),
				AlphaOpaque};
			push_entry.palette[3] = {blend_21(r1, r0), blend_21(g1, g0), blend_21(b1, b0),
				AlphaClear};
		end
		push_entry.idx_rows = blk.index_bits;
	end

endmodule

>>> hw/rtl/dxt1_queue.sv
`timescale 1ns / 1ps

module dxt1_queue
	import dxt1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  dxt1_entry_t push_entry,
	input  logic        pop,
	output dxt1_qstat_t qstat,
	output dxt1_entry_t head
);

	dxt1_entry_t           mem_q [QueueDepth];
	logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]      count_q;

	function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = count_q == QCntW'(QueueDepth);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

>>> hw/rtl/dxt1_back.sv
`timescale 1ns / 1ps

module dxt1_back
	import dxt1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dxt1_entry_t head,
	input  dxt1_qstat_t qstat,
	output logic        pop,
	dxt1_row_if.source  rows
);

	logic [RowNumW-1:0]             row_cnt_q;
	logic                           out_valid_q;
	logic [RowNumW-1:0]             row_num_q;
	logic                           last_q;
	pixel_t [PixPerRow-1:0]         pix_q;
	logic                           load;
	logic [PixPerRow-1:0][IdxW-1:0] sel;
	pixel_t [PixPerRow-1:0]         pix_d;

	// refill output register when empty or being taken
	assign load = !qstat.empty && (!out_valid_q || rows.ready);
	assign pop  = load && (row_cnt_q == LastRow);

	// row byte, leftmost pixel in top bits
	assign sel = head.idx_rows[LastRow - row_cnt_q];

	always_comb begin
		for (int k = 0; k < PixPerRow; k++) begin
			pix_d[k] = head.palette[sel[PixPerRow-1-k]];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				row_cnt_q   <= row_cnt_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (rows.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			row_num_q <= row_cnt_q;
			last_q    <= row_cnt_q == LastRow;
			pix_q     <= pix_d;
		end
	end

	assign rows.valid       = out_valid_q;
	assign rows.row_number  = row_num_q;
	assign rows.last_row    = last_q;
	assign rows.pixel_zero  = pix_q[0];
	assign rows.pixel_one   = pix_q[1];
	assign rows.pixel_two   = pix_q[2];
	assign rows.pixel_three = pix_q[3];

endmodule

>>> hw/rtl/dxt1_block_decoder.sv
`timescale 1ns / 1ps

// channel | dir | payload                                     | handshake
// blk     | in  | endpoint_first, endpoint_second, index_bits | valid/ready
// rows    | out | row_number, pixel_zero..three, last_row      | valid/ready
//
// one block request gives four row requests, one per cycle unless rows stall;
// the back end, a row per cycle when not stalled, sets block throughput.
// a block taken is written into the queue, then its first row is loaded
// into the output register (output reg) before it shows on rows.
// a two-entry palette queue lets blocks arrive while rows are stalled.
// arst_n clears queue pointers and count, row counter and output valid.

module dxt1_block_decoder
	import dxt1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dxt1_blk_if.sink   blk,
	dxt1_row_if.source rows
);

	dxt1_qstat_t qstat;
	dxt1_entry_t push_entry, head;
	logic        push, pop;

	dxt1_front u_front (
		.blk        (blk),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	dxt1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.qstat      (qstat),
		.head       (head)
	);

	dxt1_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rows   (rows)
	);

endmodule

>>> hw/rtl/dxt1_checker.sv
`timescale 1ns / 1ps

module dxt1_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  row_number,
	input logic        last_row,
	input logic [31:0] pixel_zero,
	input logic [31:0] pixel_three
);

	logic [1:0] exp_row_q;
	logic [4:0] pending_q;

	// expected row and rows owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_row_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_valid && out_ready) exp_row_q <= exp_row_q + 1'b1;
			pending_q <= pending_q + ((in_valid && in_ready) ? 5'd4 : 5'd0)
				- ((out_valid && out_ready) ? 5'd1 : 5'd0);
		end
	end

	// rows come out in order 0..3
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_number == exp_row_q)
		else $error("row out of order");

	// last flag marks row 3
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_row == (row_number == 2'd3))
		else $error("last_row mismatch");

	// no row without a block behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 5'd0)
		else $error("row without block");

	// stalled row holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_number)
			&& $stable(pixel_zero) && $stable(pixel_three))
		else $error("stalled row changed");

endmodule

bind dxt1_block_decoder dxt1_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (blk.valid),
	.in_ready    (blk.ready),
	.out_valid   (rows.valid),
	.out_ready   (rows.ready),
	.row_number  (rows.row_number),
	.last_row    (rows.last_row),
	.pixel_zero  (rows.pixel_zero),
	.pixel_three (rows.pixel_three)
);
